### design/arfp_pkg.sv
package arfp_pkg;

    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_COMMA  = 8'h2c;
    localparam logic [7:0] CHAR_PLUS   = 8'h2b;
    localparam logic [7:0] CHAR_E      = 8'h45;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7f;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_OK   = 2'd1;
    localparam logic [1:0] SEND_ERR  = 2'd2;

    typedef struct packed {
        logic       line_start;
        logic       in_frame;
        logic       payload_phase;
        logic       length_phase;
        logic       client_phase;
        logic       first_comma_seen;
        logic [1:0] send_result;
        logic [3:0] escape_run;
    } arfp_ctl_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_ready;
        logic [7:0]  client_id;
        logic [15:0] payload_length;
        logic [1:0]  send_status;
        logic        reset_request;
    } arfp_res_t;

endpackage

### design/arfp_step.sv
module arfp_step #(
    parameter int LENGTH_BITS = 16,
    parameter int ESCAPE_RUN  = 10
) (
    input  logic [7:0]             rx_byte,
    input  arfp_pkg::arfp_ctl_t    ctl,
    input  logic [7:0]             client_value,
    input  logic [LENGTH_BITS-1:0] length_value,
    input  logic [LENGTH_BITS-1:0] payload_count,
    output arfp_pkg::arfp_ctl_t    ctl_next,
    output logic [7:0]             client_value_next,
    output logic [LENGTH_BITS-1:0] length_value_next,
    output logic [LENGTH_BITS-1:0] payload_count_next,
    output arfp_pkg::arfp_res_t    res
);

    logic signed [8:0]      digit9;
    logic [LENGTH_BITS-1:0] digit_len;
    logic [7:0]             digit_client;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [3:0]             escape_inc;
    logic [15:0]            index16;

    assign digit9       = $signed({1'b0, rx_byte}) - $signed({1'b0, arfp_pkg::CHAR_ZERO});
    assign digit_len    = LENGTH_BITS'(digit9);
    assign digit_client = 8'(digit9);
    assign count_inc    = payload_count + LENGTH_BITS'(1);
    assign escape_inc   = ctl.escape_run + 4'd1;

    generate
        if (LENGTH_BITS >= 16) begin : g_wide
            assign index16  = payload_count[15:0];
        end else begin : g_narrow
            assign index16  = {{(16 - LENGTH_BITS){1'b0}}, payload_count};
        end
    endgenerate

    always_comb begin
        ctl_next           = ctl;
        client_value_next  = client_value;
        length_value_next  = length_value;
        payload_count_next = payload_count;
        res                = '0;

        if (rx_byte == arfp_pkg::CHAR_LF) begin
            ctl_next.line_start = 1'b1;
        end else if (rx_byte == arfp_pkg::CHAR_CR) begin
            ctl_next.line_start = 1'b0;
        end else begin
            if (ctl.in_frame) begin
                if (!ctl.payload_phase) begin
                    // header: ,client,length:
                    if (rx_byte != arfp_pkg::CHAR_COLON && ctl.length_phase) begin
                        length_value_next = (length_value << 3) + (length_value << 1)
                                            + digit_len;
                    end
                    if (ctl.first_comma_seen && rx_byte == arfp_pkg::CHAR_COMMA
                            && ctl.client_phase && !ctl.length_phase) begin
                        ctl_next.length_phase = 1'b1;
                        ctl_next.client_phase = 1'b0;
                    end
                    if (!ctl.first_comma_seen && rx_byte == arfp_pkg::CHAR_COMMA
                            && !ctl.client_phase) begin
                        ctl_next.client_phase     = 1'b1;
                        ctl_next.first_comma_seen = 1'b1;
                    end
                    if (rx_byte != arfp_pkg::CHAR_COMMA && ctl.client_phase) begin
                        client_value_next = (client_value << 3) + (client_value << 1)
                                            + digit_client;
                    end
                    if (rx_byte == arfp_pkg::CHAR_COLON) begin
                        if (length_value == '0) begin
                            res.frame_ready           = 1'b1;
                            ctl_next.in_frame         = 1'b0;
                            ctl_next.client_phase     = 1'b0;
                            ctl_next.length_phase     = 1'b0;
                            ctl_next.payload_phase    = 1'b0;
                            ctl_next.first_comma_seen = 1'b0;
                        end else begin
                            ctl_next.payload_phase = 1'b1;
                        end
                    end
                end else begin
                    res.payload_valid  = 1'b1;
                    res.payload_byte   = rx_byte;
                    res.payload_index  = index16;
                    payload_count_next = count_inc;
                    if (count_inc == length_value) begin
                        res.frame_ready           = 1'b1;
                        ctl_next.in_frame         = 1'b0;
                        ctl_next.client_phase     = 1'b0;
                        ctl_next.length_phase     = 1'b0;
                        ctl_next.payload_phase    = 1'b0;
                        ctl_next.first_comma_seen = 1'b0;
                    end
                end
            end
            // line-start bytes, also on the byte that closes a frame
            if (!ctl_next.in_frame && ctl.line_start) begin
                if (rx_byte == arfp_pkg::CHAR_PLUS) begin
                    ctl_next.in_frame  = 1'b1;
                    client_value_next  = '0;
                    length_value_next  = '0;
                    payload_count_next = '0;
                end else if (rx_byte == arfp_pkg::CHAR_E) begin
                    ctl_next.send_result = arfp_pkg::SEND_ERR;
                end else if (rx_byte == arfp_pkg::CHAR_S) begin
                    ctl_next.send_result = arfp_pkg::SEND_OK;
                end
                ctl_next.line_start = 1'b0;
            end
        end

        if (rx_byte == arfp_pkg::ESCAPE_BYTE) begin
            if (escape_inc == 4'(ESCAPE_RUN)) begin
                ctl_next.escape_run = 4'd0;
                res.reset_request   = 1'b1;
            end else begin
                ctl_next.escape_run = escape_inc;
            end
        end else begin
            ctl_next.escape_run = 4'd0;
        end

        res.client_id      = client_value_next;
        res.payload_length = 16'(length_value_next);
        res.send_status    = ctl_next.send_result;
    end

endmodule

### design/at_response_frame_parser_core.sv
// AT response frame parser
// s_ channel: one received serial byte per item in s_tdata[7:0]
// m_ channel: exactly one result item per input item, in order
//   m_tuser marks a payload byte, m_tlast pulses on the item that completes a frame
//   m_tdata carries byte, index, client id, length, send status and reset request
// path: an accepted input item passes the input register, then the per-byte update
//   into the result register, where m_tvalid rises
// throughput: one item per cycle while m_tready stays high; the parser state is updated
//   in a single pass of logic between the input register and the result register
// when the receiver stalls, the result register holds and the input register
//   still takes one more item, after which s_tready drops until m_tready returns
// reset (aresetn low, synchronous) clears both valid flags and all parser state:
//   no frame open, line start disarmed, send status none, escape run zero
module at_response_frame_parser_core #(
    parameter int LENGTH_BITS = 16,
    parameter int ESCAPE_RUN  = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                   // [31:24] client_id, [47:32] payload_length,
                                   // [49:48] send_status, [50] reset_request, rest zero
    output logic        m_tuser,   // [0] payload_valid
    output logic        m_tlast    // frame_ready
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   advance;

    arfp_pkg::arfp_ctl_t    ctl_reg;
    arfp_pkg::arfp_ctl_t    ctl_next;
    logic [7:0]             client_value_reg;
    logic [7:0]             client_value_next;
    logic [LENGTH_BITS-1:0] length_value_reg;
    logic [LENGTH_BITS-1:0] length_value_next;
    logic [LENGTH_BITS-1:0] payload_count_reg;
    logic [LENGTH_BITS-1:0] payload_count_next;

    arfp_pkg::arfp_res_t    res_next;
    arfp_pkg::arfp_res_t    res_reg;
    logic                   m_valid_reg;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    arfp_step #(
        .LENGTH_BITS (LENGTH_BITS),
        .ESCAPE_RUN  (ESCAPE_RUN)
    ) u_step (
        .rx_byte            (in_byte_reg),
        .ctl                (ctl_reg),
        .client_value       (client_value_reg),
        .length_value       (length_value_reg),
        .payload_count      (payload_count_reg),
        .ctl_next           (ctl_next),
        .client_value_next  (client_value_next),
        .length_value_next  (length_value_next),
        .payload_count_next (payload_count_next),
        .res                (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg           <= '0;
            client_value_reg  <= '0;
            length_value_reg  <= '0;
            payload_count_reg <= '0;
        end else if (advance) begin
            ctl_reg           <= ctl_next;
            client_value_reg  <= client_value_next;
            length_value_reg  <= length_value_next;
            payload_count_reg <= payload_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.payload_valid;
    assign m_tlast  = res_reg.frame_ready;
    assign m_tdata  = {5'd0,
                       res_reg.reset_request,
                       res_reg.send_status,
                       res_reg.payload_length,
                       res_reg.client_id,
                       res_reg.payload_index,
                       res_reg.payload_byte};

`ifndef ASSERT_OFF
    a_phase_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl_reg.client_phase && ctl_reg.length_phase))
        else $error("client and length phases both active");

    a_payload_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.payload_phase |-> ctl_reg.in_frame)
        else $error("payload phase outside a frame");

    a_payload_not_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.payload_valid) |->
        (res_reg.payload_byte != arfp_pkg::CHAR_LF &&
         res_reg.payload_byte != arfp_pkg::CHAR_CR))
        else $error("line marker emitted as payload");

    a_reset_req_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.reset_request) |=> (ctl_reg.escape_run == 4'd0))
        else $error("escape run not cleared after reset request");
`endif

endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ESCAPE_LEN   = 10;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [2:0] gap;
        logic       drain;
    } rx_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // parser state mirror
    logic        line_armed   = 1'b0;
    logic        in_frame     = 1'b0;
    logic        payload_on   = 1'b0;
    logic        length_on    = 1'b0;
    logic        client_on    = 1'b0;
    logic        comma_seen   = 1'b0;
    logic [7:0]  client_acc   = '0;
    logic [15:0] length_acc   = '0;
    logic [15:0] payload_cnt  = '0;
    logic [1:0]  send_state   = arfp_pkg::SEND_NONE;
    logic [3:0]  escape_count = '0;

    rx_item_t              rx_queue[$];
    arfp_pkg::arfp_res_t   results_due[$];
    int unsigned errors       = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    bit          drain_next   = 1'b0;

    at_response_frame_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void close_frame();
        in_frame   = 1'b0;
        client_on  = 1'b0;
        length_on  = 1'b0;
        payload_on = 1'b0;
        comma_seen = 1'b0;
    endfunction

    function automatic arfp_pkg::arfp_res_t parse_rx_byte(logic [7:0] b);
        arfp_pkg::arfp_res_t r;
        r = '0;
        if (b == arfp_pkg::CHAR_LF) begin
            line_armed = 1'b1;
        end else if (b == arfp_pkg::CHAR_CR) begin
            line_armed = 1'b0;
        end else begin
            if (in_frame) begin
                if (!payload_on) begin
                    if (b != arfp_pkg::CHAR_COLON && length_on)
                        length_acc = length_acc * 16'd10 + 16'(b)
                                     - 16'(arfp_pkg::CHAR_ZERO);
                    if (comma_seen && b == arfp_pkg::CHAR_COMMA && client_on
                            && !length_on) begin
                        length_on = 1'b1;
                        client_on = 1'b0;
                    end
                    if (!comma_seen && b == arfp_pkg::CHAR_COMMA && !client_on) begin
                        client_on  = 1'b1;
                        comma_seen = 1'b1;
                    end
                    if (b != arfp_pkg::CHAR_COMMA && client_on)
                        client_acc = client_acc * 8'd10 + b - arfp_pkg::CHAR_ZERO;
                    if (b == arfp_pkg::CHAR_COLON) begin
                        if (length_acc == 16'd0) begin
                            r.frame_ready = 1'b1;
                            close_frame();
                        end else begin
                            payload_on = 1'b1;
                        end
                    end
                end else begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = payload_cnt;
                    payload_cnt     = payload_cnt + 16'd1;
                    if (payload_cnt == length_acc) begin
                        r.frame_ready = 1'b1;
                        close_frame();
                    end
                end
            end
            if (!in_frame && line_armed) begin
                if (b == arfp_pkg::CHAR_PLUS) begin
                    in_frame    = 1'b1;
                    client_acc  = '0;
                    length_acc  = '0;
                    payload_cnt = '0;
                end else if (b == arfp_pkg::CHAR_E) begin
                    send_state = arfp_pkg::SEND_ERR;
                end else if (b == arfp_pkg::CHAR_S) begin
                    send_state = arfp_pkg::SEND_OK;
                end
                line_armed = 1'b0;
            end
        end
        if (b == arfp_pkg::ESCAPE_BYTE) begin
            escape_count = escape_count + 4'd1;
            if (escape_count == 4'(ESCAPE_LEN)) begin
                escape_count    = '0;
                r.reset_request = 1'b1;
            end
        end else begin
            escape_count = '0;
        end
        r.client_id      = client_acc;
        r.payload_length = length_acc;
        r.send_status    = send_state;
        return r;
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    task automatic push_byte(logic [7:0] b);
        rx_item_t item;
        item.rx_byte = b;
        // some stretches run back to back
        item.gap     = ((rx_queue.size() / 96) % 3 == 1) ? 3'd0 : 3'($urandom_range(0, 7));
        item.drain   = drain_next;
        drain_next   = 1'b0;
        rx_queue.push_back(item);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_frame(int unsigned id, int unsigned len, int unsigned wraps);
        int unsigned counted;
        logic [7:0]  b;
        counted = 0;
        push_text($sformatf("\r\n+IPD,%0d,%0d:", id, len + 65536 * wraps));
        while (counted < len) begin
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            if (b != arfp_pkg::CHAR_LF && b != arfp_pkg::CHAR_CR)
                counted++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (!aresetn) begin
            next_valid = 1'b0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(parse_rx_byte(s_tdata));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (rx_queue.size() > 0 &&
                             !(rx_queue[0].drain && results_due.size() != 0)) begin
                    s_tdata    <= rx_queue[0].rx_byte;
                    gap_left   = int'(rx_queue[0].gap);
                    next_valid = 1'b1;
                    void'(rx_queue.pop_front());
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // monitor
    always @(posedge aclk) begin
        arfp_pkg::arfp_res_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: item expected none actual %0h", $time, m_tdata);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("payload_valid", 16'(want.payload_valid), 16'(m_tuser));
                    check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
                    check_field("payload_index", want.payload_index, m_tdata[23:8]);
                    check_field("frame_ready", 16'(want.frame_ready), 16'(m_tlast));
                    check_field("client_id", 16'(want.client_id), 16'(m_tdata[31:24]));
                    check_field("payload_length", want.payload_length, m_tdata[47:32]);
                    check_field("send_status", 16'(want.send_status),
                                16'(m_tdata[49:48]));
                    check_field("reset_request", 16'(want.reset_request),
                                16'(m_tdata[50]));
                    check_field("tdata padding", 16'd0, 16'(m_tdata[55:51]));
                end
                results_seen++;
                stall_left = ((results_seen / 128) % 3 == 2) ? 0 : $urandom_range(0, 7);
            end
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int unsigned start_size;
        int unsigned sel;
        bit          drained;
        drained = 1'b0;

        // byte extremes, send status, payload with line markers and colon,
        // completion byte reopening a frame, zero length, escape run
        push_byte(8'h00);
        push_byte(8'hff);
        push_text("\nE\nS");
        push_text("\n+,7,2:");
        push_text(":\n+");
        push_text(",,:");
        repeat (ESCAPE_LEN) push_byte(arfp_pkg::ESCAPE_BYTE);

        start_size = rx_queue.size();
        drain_next = 1'b1;
        while (rx_queue.size() < start_size + RANDOM_ITEMS) begin
            if (!drained && rx_queue.size() > start_size + RANDOM_ITEMS / 2) begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                push_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 999)
                                                       : $urandom_range(0, 9),
                           ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 12),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0);
            end else if (sel < 65) begin
                case ($urandom_range(0, 2))
                    0: push_text("\r\nSEND OK\r\n");
                    1: push_text("\r\nERROR\r\n");
                    default: push_text("\r\nOK\r\n");
                endcase
            end else if (sel < 72) begin
                repeat ($urandom_range(8, 22)) push_byte(arfp_pkg::ESCAPE_BYTE);
            end else if (sel < 80) begin
                // truncated or malformed header
                push_text("\r\n+IPD,");
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: push_byte(arfp_pkg::CHAR_COMMA);
                        1: push_byte(arfp_pkg::CHAR_COLON);
                        2: push_byte(8'($urandom_range(0, 255)));
                        default: push_byte(arfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (rx_queue.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
design/arfp_pkg.sv
design/arfp_step.sv
design/at_response_frame_parser_core.sv
test/tb.sv
